FILE: src/mono_framebuffer_draw_engine_top_macros.svh
// assertion macros for the framebuffer draw engine
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MFB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("mfb assertion failed");
`define MFB_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("mfb assertion failed");
`else
`define MFB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define MFB_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

FILE: src/mfb_pkg.sv
// types and constants of the framebuffer draw engine
package mfb_pkg;

  localparam int CRD_W = 18;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_GET     = 3'd1,
    OP_HLINE   = 3'd2,
    OP_VLINE   = 3'd3,
    OP_FILL    = 3'd4,
    OP_OUTLINE = 3'd5,
    OP_CIRCLE  = 3'd6,
    OP_CLEAR   = 3'd7
  } mfb_op_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PASS, S_ROW, S_DY, S_SQ, S_SQW, S_COLS,
    S_RD, S_WR, S_GET, S_GETW, S_CLR, S_DONE
  } mfb_state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mfb_mem_ctl_t;

endpackage

FILE: src/mfb_store.sv
// frame byte memory, one write and one registered read port
module mfb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  mfb_pkg::mfb_mem_ctl_t ctl,
  input  logic [AW-1:0]         waddr,
  input  logic [7:0]            wdata,
  input  logic [AW-1:0]         raddr,
  output logic [7:0]            rdata
);
  import mfb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: src/mfb_isqrt.sv
// iterative integer square root, one result bit per cycle
module mfb_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] operand,
  output logic        done,
  output logic [15:0] root
);
  import mfb_pkg::*;

  logic [31:0] rem_r, res_r, bit_r;
  logic        busy_r, done_r;
  logic [31:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= operand;
        res_r  <= 32'd0;
        bit_r  <= 32'h4000_0000;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[15:0];
endmodule

FILE: src/mono_framebuffer_draw_engine_top.sv
// framebuffer draw engine top level: command sequencer with byte read-modify-write
// set/draw read and then write each touched byte, after a row setup per row and a pass setup per pass;
// circle rows also wait for the square root; get reads the addressed byte and then reports its bit
// clear writes one byte per cycle over all ROW_BYTES*SCREEN_HEIGHT bytes
// throughput: one item at a time, since in_ready is high only while the sequencer is idle
// after reset the memory is swept to zero one byte at a time, with in_ready low
`include "mono_framebuffer_draw_engine_top_macros.svh"
module mono_framebuffer_draw_engine_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic signed [15:0] in_span_width,
  input  logic signed [15:0] in_span_height,
  input  logic signed [15:0] in_radius,
  input  logic               in_pixel_on,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_pixel_value
);
  import mfb_pkg::*;

  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int DEPTH     = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = ($clog2(SCREEN_WIDTH) < 4) ? 4 : $clog2(SCREEN_WIDTH);
  localparam int RW        = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int BW        = CW - 3;
  localparam logic signed [CRD_W-1:0] XMAX = CRD_W'(SCREEN_WIDTH - 1);
  localparam logic signed [CRD_W-1:0] YMAX = CRD_W'(SCREEN_HEIGHT - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  mfb_state_t state_r, state_nxt;

  mfb_op_t            op_r;
  logic signed [15:0] x_r, y_r, w_r, h_r, rad_r;
  logic               on_r;
  logic [1:0]         phase_r;
  logic [RW-1:0]      row_cur_r, row_end_r;
  logic [AW-1:0]      row_base_r;
  logic signed [CRD_W-1:0] col_lo_r, col_hi_r;
  logic [CW-1:0]      ca_r, cb_r;
  logic [BW-1:0]      byte_cur_r, byte_end_r;
  logic [31:0]        r2_r, dy2_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               res_val_r, get_ok_r;
  logic               out_valid_r, out_val_r;

  mfb_mem_ctl_t  mem_ctl;
  logic [AW-1:0] mem_waddr, mem_raddr, cur_addr, get_addr;
  logic [7:0]    mem_wdata, mem_rdata, mask;
  logic          sq_start, sq_done;
  logic [15:0]   sq_root;

  logic signed [CRD_W-1:0] xs, ys, ws, hs, rs;
  logic signed [CRD_W-1:0] rlo, rhi, clo, chi, dy, absdy, root_s;
  logic          rows_empty, cols_empty, row_last, byte_last, last_pass;
  logic          in_acc, get_onscreen, outline_skip;
  logic [RW-1:0] ra, rb;
  logic [CW-1:0] ca, cb;
  logic [2:0]    m_lo, m_hi;

  assign xs = CRD_W'(x_r);
  assign ys = CRD_W'(y_r);
  assign ws = CRD_W'(w_r);
  assign hs = CRD_W'(h_r);
  assign rs = CRD_W'(rad_r);

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign outline_skip = (in_req_type == OP_OUTLINE) &&
                        ((in_span_width <= 16'sd0) || (in_span_height <= 16'sd0));

  // raw extent of the current pass
  always_comb begin
    rlo = ys;
    rhi = ys;
    clo = xs;
    chi = xs;
    case (op_r)
      OP_HLINE: begin
        chi = xs + ws - 18'sd1;
      end
      OP_VLINE: begin
        rhi = ys + hs - 18'sd1;
      end
      OP_FILL: begin
        rhi = ys + hs - 18'sd1;
        chi = xs + ws - 18'sd1;
      end
      OP_OUTLINE: begin
        case (phase_r)
          2'd0: begin
            chi = xs + ws - 18'sd1;
          end
          2'd1: begin
            rlo = ys + hs - 18'sd1;
            rhi = ys + hs - 18'sd1;
            chi = xs + ws - 18'sd1;
          end
          2'd2: begin
            rhi = ys + hs - 18'sd1;
          end
          default: begin
            rhi = ys + hs - 18'sd1;
            clo = xs + ws - 18'sd1;
            chi = xs + ws - 18'sd1;
          end
        endcase
      end
      OP_CIRCLE: begin
        rlo = ys - rs;
        rhi = ys + rs;
      end
      default: begin
      end
    endcase
  end

  assign rows_empty = (rlo > rhi) || (rhi < 0) || (rlo > YMAX);
  assign ra = (rlo < 0) ? RW'(0) : rlo[RW-1:0];
  assign rb = (rhi > YMAX) ? YMAX[RW-1:0] : rhi[RW-1:0];

  assign cols_empty = (col_lo_r > col_hi_r) || (col_hi_r < 0) || (col_lo_r > XMAX);
  assign ca = (col_lo_r < 0) ? CW'(0) : col_lo_r[CW-1:0];
  assign cb = (col_hi_r > XMAX) ? XMAX[CW-1:0] : col_hi_r[CW-1:0];

  assign dy     = CRD_W'(row_cur_r) - ys;
  assign absdy  = (dy < 0) ? -dy : dy;
  assign root_s = $signed({2'b00, sq_root});

  assign row_last  = (row_cur_r == row_end_r);
  assign byte_last = (byte_cur_r == byte_end_r);
  assign last_pass = !((op_r == OP_OUTLINE) && (phase_r != 2'd3));

  assign cur_addr = AW'(row_base_r + AW'(byte_cur_r));
  assign get_onscreen = (xs >= 0) && (xs <= XMAX) && (ys >= 0) && (ys <= YMAX);
  assign get_addr = AW'(y_r[RW-1:0] * ROW_BYTES + x_r[CW-1:3]);

  // pixel mask inside the current byte, msb is the leftmost pixel
  assign m_lo = (byte_cur_r == ca_r[CW-1:3]) ? ca_r[2:0] : 3'd0;
  assign m_hi = (byte_cur_r == cb_r[CW-1:3]) ? cb_r[2:0] : 3'd7;
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      mask[7-p] = (3'(p) >= m_lo) && (3'(p) <= m_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_ctl   = '0;
    mem_waddr = cur_addr;
    mem_raddr = cur_addr;
    mem_wdata = on_r ? (mem_rdata | mask) : (mem_rdata & ~mask);
    sq_start  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = clr_cnt_r;
        mem_wdata  = 8'h00;
        if (clr_cnt_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == OP_GET) state_nxt = S_GET;
          else if (in_req_type == OP_CLEAR) state_nxt = S_CLR;
          else if (outline_skip) state_nxt = S_DONE;
          else state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        if (rows_empty) state_nxt = last_pass ? S_DONE : S_PASS;
        else state_nxt = S_ROW;
      end
      S_ROW: begin
        state_nxt = (op_r == OP_CIRCLE) ? S_DY : S_COLS;
      end
      S_DY: begin
        state_nxt = S_SQ;
      end
      S_SQ: begin
        sq_start  = 1'b1;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (sq_done) state_nxt = S_COLS;
      end
      S_COLS: begin
        if (!cols_empty) state_nxt = S_RD;
        else if (!row_last) state_nxt = S_ROW;
        else state_nxt = last_pass ? S_DONE : S_PASS;
      end
      S_RD: begin
        mem_ctl.re = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        mem_ctl.we = 1'b1;
        if (!byte_last) state_nxt = S_RD;
        else if (!row_last) state_nxt = S_ROW;
        else state_nxt = last_pass ? S_DONE : S_PASS;
      end
      S_GET: begin
        mem_ctl.re = 1'b1;
        mem_raddr  = get_addr;
        state_nxt  = S_GETW;
      end
      S_GETW: begin
        state_nxt = S_DONE;
      end
      S_CLR: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = clr_cnt_r;
        mem_wdata  = 8'h00;
        if (clr_cnt_r == LAST_ADDR) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 2'd0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_val_r   <= res_val_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT, S_CLR: begin
          clr_cnt_r <= (clr_cnt_r == LAST_ADDR) ? '0 : clr_cnt_r + AW'(1);
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r      <= mfb_op_t'(in_req_type);
            x_r       <= in_x_pos;
            y_r       <= in_y_pos;
            w_r       <= in_span_width;
            h_r       <= in_span_height;
            rad_r     <= in_radius;
            on_r      <= in_pixel_on;
            phase_r   <= 2'd0;
            clr_cnt_r <= '0;
            res_val_r <= 1'b0;
          end
        end
        S_PASS: begin
          row_cur_r <= ra;
          row_end_r <= rb;
          col_lo_r  <= clo;
          col_hi_r  <= chi;
          r2_r      <= {17'b0, rad_r[14:0]} * {17'b0, rad_r[14:0]};
          if (rows_empty) phase_r <= phase_r + 2'd1;
        end
        S_ROW: begin
          row_base_r <= AW'(row_cur_r * ROW_BYTES);
        end
        S_DY: begin
          dy2_r <= {16'b0, absdy[15:0]} * {16'b0, absdy[15:0]};
        end
        S_SQW: begin
          if (sq_done) begin
            col_lo_r <= xs - root_s;
            col_hi_r <= xs + root_s;
          end
        end
        S_COLS: begin
          ca_r       <= ca;
          cb_r       <= cb;
          byte_cur_r <= ca[CW-1:3];
          byte_end_r <= cb[CW-1:3];
          if (cols_empty) begin
            if (!row_last) row_cur_r <= row_cur_r + RW'(1);
            else phase_r <= phase_r + 2'd1;
          end
        end
        S_WR: begin
          if (!byte_last) byte_cur_r <= byte_cur_r + BW'(1);
          else if (!row_last) row_cur_r <= row_cur_r + RW'(1);
          else phase_r <= phase_r + 2'd1;
        end
        S_GET: begin
          get_ok_r <= get_onscreen;
        end
        S_GETW: begin
          res_val_r <= get_ok_r & mem_rdata[~x_r[2:0]];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_val_r;

  mfb_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  mfb_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .operand(r2_r - dy2_r),
    .done   (sq_done),
    .root   (sq_root)
  );

  `MFB_ASSERT_IMP(a_we_state, clk, rst_n, mem_ctl.we, (state_r == S_WR) || (state_r == S_CLR) || (state_r == S_INIT))
  `MFB_ASSERT_NXT(a_rd_then_wr, clk, rst_n, state_r == S_RD, state_r == S_WR)
  `MFB_ASSERT_IMP(a_sq_done_wait, clk, rst_n, sq_done, state_r == S_SQW)
  `MFB_ASSERT_NXT(a_acc_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
endmodule

FILE: sim/mono_framebuffer_draw_engine_checker.sv
// checker: predicts framebuffer results and compares them with the out channel
`timescale 1ns / 100ps
module mono_framebuffer_draw_engine_checker #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic signed [15:0] in_span_width,
  input  logic signed [15:0] in_span_height,
  input  logic signed [15:0] in_radius,
  input  logic               in_pixel_on,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_pixel_value,
  output int                 fail_count,
  output int                 pending_count
);
  import mfb_pkg::*;

  localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;

  logic [7:0] pic [STORE_BYTES];
  logic pixel_queue [$];

  function automatic void plot(int x, int y, logic on);
    int idx;
    logic [7:0] m;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
    idx = y * ROW_BYTES + x / 8;
    m = 8'h80 >> (x % 8);
    if (on) pic[idx] = pic[idx] | m;
    else pic[idx] = pic[idx] & ~m;
  endfunction

  function automatic logic peek(int x, int y);
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return 1'b0;
    return pic[y * ROW_BYTES + x / 8][7 - x % 8];
  endfunction

  function automatic void span_h(int x, int y, int w, logic on);
    int a, b;
    if (y < 0 || y >= SCREEN_HEIGHT || w <= 0) return;
    a = x < 0 ? 0 : x;
    b = x + w - 1;
    if (b > SCREEN_WIDTH - 1) b = SCREEN_WIDTH - 1;
    for (int i = a; i <= b; i++) plot(i, y, on);
  endfunction

  function automatic void span_v(int x, int y, int h, logic on);
    int a, b;
    if (x < 0 || x >= SCREEN_WIDTH || h <= 0) return;
    a = y < 0 ? 0 : y;
    b = y + h - 1;
    if (b > SCREEN_HEIGHT - 1) b = SCREEN_HEIGHT - 1;
    for (int i = a; i <= b; i++) plot(x, i, on);
  endfunction

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned res, bt;
    res = 0;
    bt = 32'h4000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic void fill_disc(int cx, int cy, int r, logic on);
    int a, b, dy, d;
    int unsigned r2, dy2;
    if (r < 0) return;
    if (r == 0) begin
      plot(cx, cy, on);
      return;
    end
    r2 = r * r;
    a = cy - r < 0 ? 0 : cy - r;
    b = cy + r > SCREEN_HEIGHT - 1 ? SCREEN_HEIGHT - 1 : cy + r;
    for (int py = a; py <= b; py++) begin
      dy = py - cy;
      dy2 = dy < 0 ? -dy : dy;
      dy2 = dy2 * dy2;
      d = int_sqrt(r2 - dy2);
      span_h(cx - d, py, d * 2 + 1, on);
    end
  endfunction

  function automatic logic draw_command(mfb_op_t op, int x, int y, int w, int h, int r,
                                        logic on);
    logic v;
    v = 1'b0;
    case (op)
      OP_SET: plot(x, y, on);
      OP_GET: v = peek(x, y);
      OP_HLINE: span_h(x, y, w, on);
      OP_VLINE: span_v(x, y, h, on);
      OP_FILL: begin
        if (w > 0 && h > 0)
          for (int iy = (y < 0 ? 0 : y); iy <= y + h - 1 && iy < SCREEN_HEIGHT; iy++)
            span_h(x, iy, w, on);
      end
      OP_OUTLINE: begin
        if (w > 0 && h > 0) begin
          span_h(x, y, w, on);
          span_h(x, y + h - 1, w, on);
          span_v(x, y, h, on);
          span_v(x + w - 1, y, h, on);
        end
      end
      OP_CIRCLE: fill_disc(x, y, r, on);
      default: foreach (pic[i]) pic[i] = 8'h00;
    endcase
    return v;
  endfunction

  assign pending_count = pixel_queue.size();

  always @(posedge clk) begin
    logic e;
    if (!rst_n) begin
      foreach (pic[i]) pic[i] = 8'h00;
      pixel_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        pixel_queue.push_back(draw_command(mfb_op_t'(in_req_type), in_x_pos, in_y_pos,
          in_span_width, in_span_height, in_radius, in_pixel_on));
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected item: pixel_value actual %0d", out_pixel_value);
          fail_count <= fail_count + 1;
        end else begin
          e = pixel_queue.pop_front();
          if (e !== out_pixel_value) begin
            $error("pixel_value mismatch: expected %0d actual %0d", e, out_pixel_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: sim/mono_framebuffer_draw_engine_top_test.sv
// testbench top: stimulus, idling and verdict for the framebuffer draw engine
`timescale 1ns / 100ps
module mono_framebuffer_draw_engine_top_test;
  import mfb_pkg::*;

  localparam int WATCHDOG = 200000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_pixel_on;
  logic [2:0] in_req_type;
  logic signed [15:0] in_x_pos, in_y_pos, in_span_width, in_span_height, in_radius;
  logic out_valid, out_ready, out_pixel_value;
  int fail_count, pending_count, idle_cycles;
  bit hold_rx, rx_free;

  mono_framebuffer_draw_engine_top DUT (.*);

  mono_framebuffer_draw_engine_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] pick_coord(int lim);
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 16'(int'($urandom_range(0, lim + 8)) - 4);
    if (p < 90) return 16'(-$urandom_range(0, 40));
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_size(int lim);
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 16'($urandom_range(0, lim));
    if (p < 90) return 16'(-$urandom_range(0, 5));
    return 16'($urandom);
  endfunction

  task automatic send(logic [2:0] op, int x, int y, int w, int h, int r, logic on);
    in_valid <= 1'b1;
    in_req_type <= op;
    in_x_pos <= 16'(x);
    in_y_pos <= 16'(y);
    in_span_width <= 16'(w);
    in_span_height <= 16'(h);
    in_radius <= 16'(r);
    in_pixel_on <= on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random();
    mfb_op_t op;
    int p, w, h;
    p = $urandom_range(0, 99);
    if (p < 30) op = OP_GET;
    else if (p < 45) op = OP_SET;
    else if (p < 99) op = mfb_op_t'($urandom_range(2, 6));
    else op = OP_CLEAR;
    w = pick_size(($urandom_range(0, 9) == 0) ? 140 : 20);
    h = pick_size(($urandom_range(0, 9) == 0) ? 70 : 12);
    send(op, pick_coord(128), pick_coord(64), w, h,
         ($urandom_range(0, 19) == 0) ? int'(16'($urandom)) : int'(pick_size(20)),
         1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_rx) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_free || $urandom_range(0, 99) < 70) out_ready <= 1'b1;
      else out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("mono_framebuffer_draw_engine_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = OP_SET;
    in_x_pos = '0;
    in_y_pos = '0;
    in_span_width = '0;
    in_span_height = '0;
    in_radius = '0;
    in_pixel_on = 1'b0;
    out_ready = 1'b0;
    hold_rx = 1'b0;
    rx_free = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    rx_free <= 1'b1;
    send(OP_GET, 0, 0, 0, 0, 0, 1'b1);
    send(OP_SET, 0, 0, 0, 0, 0, 1'b1);
    send(OP_GET, 0, 0, 0, 0, 0, 1'b0);
    send(OP_SET, 127, 63, 0, 0, 0, 1'b1);
    send(OP_GET, 127, 63, 0, 0, 0, 1'b0);
    send(OP_SET, 128, 0, 0, 0, 0, 1'b1);
    send(OP_GET, -1, -1, 0, 0, 0, 1'b0);
    send(OP_HLINE, -5, 3, 200, 0, 0, 1'b1);
    send(OP_GET, 100, 3, 0, 0, 0, 1'b0);
    send(OP_HLINE, 3, 4, 0, 0, 0, 1'b1);
    send(OP_VLINE, 9, -10, 32767, 32767, 0, 1'b1);
    send(OP_VLINE, 10, 5, 0, -32768, 0, 1'b1);
    send(OP_FILL, 20, 20, 10, 8, 0, 1'b1);
    send(OP_FILL, 22, 22, 4, 4, 0, 1'b0);
    send(OP_FILL, 0, 0, -32768, 5, 0, 1'b1);
    send(OP_OUTLINE, 40, 10, 1, 1, 0, 1'b1);
    send(OP_OUTLINE, -3, -3, 140, 70, 0, 1'b1);
    send(OP_CIRCLE, 64, 32, 0, 0, 0, 1'b1);
    send(OP_CIRCLE, 64, 32, 0, 0, 10, 1'b0);
    send(OP_CIRCLE, 0, 0, 0, 0, -1, 1'b1);
    send(OP_CIRCLE, -32768, 32767, 0, 0, 32767, 1'b1);
    send(OP_GET, 64, 32, 0, 0, 0, 1'b0);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 1'b0);
    send(OP_GET, 127, 63, 0, 0, 0, 1'b0);
    rx_free <= 1'b0;
    for (int n = 0; n < 950; n++) begin
      if (n == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
      if (n == 500) begin
        fork
          begin
            hold_rx = 1'b1;
            repeat (3000) @(posedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      if (n % 97 < 10) send_random();
      else begin
        send_random();
        send_gap();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("mono_framebuffer_draw_engine_top_test: done, clean");
    else
      $display("mono_framebuffer_draw_engine_top_test: done, errors");
    $finish;
  end
endmodule
